### src/gbd_pkg.sv
// Shared types, constants and the scale/round/saturate function for the
// grid backward-difference gradient/divergence block. No dependencies.
package gbd_pkg;

    localparam int DATA_W = 16;                 // Q4.12 input field
    localparam int RES_W  = 24;                 // saturated result field
    localparam int DIFF_W = 19;                 // sum of three 17-bit differences
    localparam int KINV_W = DATA_W + 1;         // reciprocal as a signed operand
    localparam int PROD_W = DIFF_W + KINV_W;    // exact product width
    localparam int RSH_W  = PROD_W - 11;        // product after the rounding shift
    localparam int FRAC_W = 12;
    localparam int CNT_W  = 9;                  // holds any axis count up to 256
    localparam int CFG_W  = 16;

    localparam logic [CFG_W-1:0] INV_RESET   = 16'd2048;
    localparam logic [4:0]       COUNT_RESET = 5'd3;

    typedef enum logic [1:0] {
        CFG_INV_LEN = 2'd0,
        CFG_X_COUNT = 2'd1,
        CFG_Y_COUNT = 2'd2,
        CFG_Z_COUNT = 2'd3
    } t_cfg_idx;

    // packed grid word: density in the low half-word, vel_z on top
    typedef struct packed {
        logic [DATA_W-1:0] vel_z;
        logic [DATA_W-1:0] vel_y;
        logic [DATA_W-1:0] vel_x;
        logic [DATA_W-1:0] density;
    } t_cell;

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             sat;
    } t_scaled;

    localparam logic signed [PROD_W:0]  ROUND_K = (PROD_W+1)'(1 << (FRAC_W - 1));
    localparam logic signed [RSH_W-1:0] SAT_HI  = RSH_W'((1 << (RES_W - 1)) - 1);
    localparam logic signed [RSH_W-1:0] SAT_LO  = RSH_W'(-(1 << (RES_W - 1)));

    // difference of two Q4.12 fields, widened so three of them add exactly
    function automatic logic signed [DIFF_W-1:0] field_diff(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        return DIFF_W'($signed(a)) - DIFF_W'($signed(b));
    endfunction

    // Q12.24 product -> Q12.12, round half up, clip to 24 bits
    function automatic t_scaled scale_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0]  biased;
        logic signed [RSH_W-1:0] r;
        t_scaled                 s;
        biased = (PROD_W+1)'(p) + ROUND_K;
        r      = biased[PROD_W:FRAC_W];
        if (r > SAT_HI) begin
            s.value = SAT_HI[RES_W-1:0];
            s.sat   = 1'b1;
        end else if (r < SAT_LO) begin
            s.value = SAT_LO[RES_W-1:0];
            s.sat   = 1'b1;
        end else begin
            s.value = r[RES_W-1:0];
            s.sat   = 1'b0;
        end
        return s;
    endfunction

endpackage

### src/gbd_cell.sv
// One stage of the row delay chain: holds one grid word and passes it on.
// Depends on gbd_pkg for the word type.
module gbd_cell
    import gbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_cell i_d,
    output t_cell o_q
);

    t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

### src/gbd_row_chain.sv
// Row delay chain built from gbd_cell stages; gives the previous word and
// the word one row back. Depends on gbd_pkg and gbd_cell.
module gbd_row_chain
    import gbd_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int TAP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  t_cell            i_d,
    input  logic [TAP_W-1:0] i_tap,
    output t_cell            o_first,
    output t_cell            o_tap
);

    t_cell w_q [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_stage
        if (g == 0) begin : g_head
            gbd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_d     (i_d),
                .o_q     (w_q[g])
            );
        end else begin : g_body
            gbd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_d     (w_q[g-1]),
                .o_q     (w_q[g])
            );
        end
    end

    assign o_first = w_q[0];
    assign o_tap   = w_q[i_tap];

endmodule

### src/gbd_plane_store.sv
// Plane store: one grid word per (y,z), one write and one registered read
// port, read-before-write on a shared address. Depends on gbd_pkg.
module gbd_plane_store
    import gbd_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_addr,
    input  t_cell         i_wr_data,
    output t_cell         o_rd_data
);

    t_cell r_mem [DEPTH];
    t_cell r_rd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd         <= r_mem[i_addr];
            r_mem[i_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd;

endmodule

### src/grid_backward_diff_grad_div.sv
// A word accepted by the block is fetched at the accept edge, then passes through the
// registered difference, multiply and round stages to the output ports; a stall can
// hold it in any of them.
// Throughput: one word per cycle; each stage stalls only when the one after it
// is full, and the output register frees the input side while a result waits.
// The plane store is a single-port-address RAM read and written at the accept
// edge. Reset (synchronous, active low) empties the pipeline, restores the
// registers and restarts the scan at the origin; the store needs no clearing.
module grid_backward_diff_grad_div
    import gbd_pkg::*;
#(
    parameter int MAX_X = 16,
    parameter int MAX_Y = 16,
    parameter int MAX_Z = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_wr_en,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // input words
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_density,
    input  logic signed [DATA_W-1:0] i_vel_x,
    input  logic signed [DATA_W-1:0] i_vel_y,
    input  logic signed [DATA_W-1:0] i_vel_z,
    // result words
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [RES_W-1:0]  o_grad_x,
    output logic signed [RES_W-1:0]  o_grad_y,
    output logic signed [RES_W-1:0]  o_grad_z,
    output logic signed [RES_W-1:0]  o_divergence,
    output logic                     o_saturated,
    output logic                     o_last_cell
);

    localparam int X_W   = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int Y_W   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int Z_W   = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int DEPTH = MAX_Y * MAX_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_inv;
    logic [4:0]       r_x_count, r_y_count, r_z_count;
    logic             w_cnt_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv     <= INV_RESET;
            r_x_count <= COUNT_RESET;
            r_y_count <= COUNT_RESET;
            r_z_count <= COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_INV_LEN: r_inv     <= i_cfg_data;
                CFG_X_COUNT: r_x_count <= i_cfg_data[4:0];
                CFG_Y_COUNT: r_y_count <= i_cfg_data[4:0];
                CFG_Z_COUNT: r_z_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // any count write restarts the scan
    assign w_cnt_wr = i_cfg_wr_en && (t_cfg_idx'(i_cfg_index) != CFG_INV_LEN);

    // clamp counts to 1..MAX and take the last position on each axis
    logic [CNT_W-1:0] w_cnt_x, w_cnt_y, w_cnt_z;
    logic [X_W-1:0]   w_lim_x;
    logic [Y_W-1:0]   w_lim_y;
    logic [Z_W-1:0]   w_lim_z;

    always_comb begin
        w_cnt_x = (r_x_count == '0) ? CNT_W'(1) :
                  ((CNT_W'(r_x_count) > CNT_W'(MAX_X)) ? CNT_W'(MAX_X) : CNT_W'(r_x_count));
        w_cnt_y = (r_y_count == '0) ? CNT_W'(1) :
                  ((CNT_W'(r_y_count) > CNT_W'(MAX_Y)) ? CNT_W'(MAX_Y) : CNT_W'(r_y_count));
        w_cnt_z = (r_z_count == '0) ? CNT_W'(1) :
                  ((CNT_W'(r_z_count) > CNT_W'(MAX_Z)) ? CNT_W'(MAX_Z) : CNT_W'(r_z_count));
        w_lim_x = X_W'(w_cnt_x - CNT_W'(1));
        w_lim_y = Y_W'(w_cnt_y - CNT_W'(1));
        w_lim_z = Z_W'(w_cnt_z - CNT_W'(1));
    end

    // ---------------- pipeline handshake ----------------
    // Each stage loads when it is empty or its successor loads too.
    logic r_v1, r_v2, r_v3, r_vo;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy_o;
    logic w_acc;

    assign w_rdy_o    = !r_vo || i_out_ready;
    assign w_rdy3     = !r_v3 || w_rdy_o;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;
    assign w_acc      = i_in_valid && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_rdy1)  r_v1 <= i_in_valid;
            if (w_rdy2)  r_v2 <= r_v1;
            if (w_rdy3)  r_v3 <= r_v2;
            if (w_rdy_o) r_vo <= r_v3;
        end
    end

    // ---------------- scan position ----------------
    logic [X_W-1:0] r_pos_x;
    logic [Y_W-1:0] r_pos_y;
    logic [Z_W-1:0] r_pos_z;
    logic           w_last;

    assign w_last = (r_pos_x == w_lim_x) && (r_pos_y == w_lim_y) && (r_pos_z == w_lim_z);

    // z fastest, then y, then x; wrap to the origin after the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cnt_wr) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
        end else if (w_acc) begin
            if (r_pos_z != w_lim_z) begin
                r_pos_z <= r_pos_z + Z_W'(1);
            end else begin
                r_pos_z <= '0;
                if (r_pos_y != w_lim_y) begin
                    r_pos_y <= r_pos_y + Y_W'(1);
                end else begin
                    r_pos_y <= '0;
                    r_pos_x <= (r_pos_x != w_lim_x) ? r_pos_x + X_W'(1) : '0;
                end
            end
        end
    end

    // ---------------- neighbor fetch ----------------
    t_cell          w_cur;
    t_cell          w_nx_raw, w_prev, w_row;
    logic [AW-1:0]  w_addr;

    assign w_cur  = '{vel_z: i_vel_z, vel_y: i_vel_y, vel_x: i_vel_x, density: i_density};
    assign w_addr = AW'(32'(r_pos_y) * MAX_Z + 32'(r_pos_z));

    // x-neighbor: same (y,z) of the previous plane, read before overwrite
    gbd_plane_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_plane_store (
        .i_clk     (i_clk),
        .i_en      (w_acc),
        .i_addr    (w_addr),
        .i_wr_data (w_cur),
        .o_rd_data (w_nx_raw)
    );

    // z-neighbor is the previous word, y-neighbor the word one row back
    gbd_row_chain #(
        .DEPTH (MAX_Z),
        .TAP_W (Z_W)
    ) u_row_chain (
        .i_clk   (i_clk),
        .i_shift (w_acc),
        .i_d     (w_cur),
        .i_tap   (w_lim_z),
        .o_first (w_prev),
        .o_tap   (w_row)
    );

    // stage 1: word and its neighbors (x-neighbor data sits in the store)
    t_cell r1_cur, r1_ny, r1_nz;
    logic  r1_has_x, r1_has_y, r1_has_z, r1_last;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r1_cur   <= w_cur;
            r1_ny    <= w_row;
            r1_nz    <= w_prev;
            r1_has_x <= (r_pos_x != '0);
            r1_has_y <= (r_pos_y != '0);
            r1_has_z <= (r_pos_z != '0);
            r1_last  <= w_last;
        end
    end

    // stage 2: backward differences, off-grid neighbors count as zero
    t_cell                    w_nx, w_ny, w_nz;
    logic signed [DIFF_W-1:0] r2_d [4];
    logic                     r2_last;

    assign w_nx = r1_has_x ? w_nx_raw : '0;
    assign w_ny = r1_has_y ? r1_ny    : '0;
    assign w_nz = r1_has_z ? r1_nz    : '0;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_d[0] <= field_diff(r1_cur.density, w_nx.density);
            r2_d[1] <= field_diff(r1_cur.density, w_ny.density);
            r2_d[2] <= field_diff(r1_cur.density, w_nz.density);
            r2_d[3] <= field_diff(r1_cur.vel_x, w_nx.vel_x)
                     + field_diff(r1_cur.vel_y, w_ny.vel_y)
                     + field_diff(r1_cur.vel_z, w_nz.vel_z);
            r2_last <= r1_last;
        end
    end

    // stage 3: scale each term by the reciprocal cell length
    logic signed [KINV_W-1:0] w_k;
    logic signed [PROD_W-1:0] r3_p [4];
    logic                     r3_last;

    assign w_k = $signed({1'b0, r_inv});

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            for (int i = 0; i < 4; i++) begin
                r3_p[i] <= r2_d[i] * w_k;
            end
            r3_last <= r2_last;
        end
    end

    // output stage: round to Q12.12 and saturate
    t_scaled w_s [4];
    t_scaled r_o [4];
    logic    r_o_last;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_s[i] = scale_sat(r3_p[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_o) begin
            for (int i = 0; i < 4; i++) begin
                r_o[i] <= w_s[i];
            end
            r_o_last <= r3_last;
        end
    end

    assign o_out_valid  = r_vo;
    assign o_grad_x     = $signed(r_o[0].value);
    assign o_grad_y     = $signed(r_o[1].value);
    assign o_grad_z     = $signed(r_o[2].value);
    assign o_divergence = $signed(r_o[3].value);
    assign o_saturated  = r_o[0].sat || r_o[1].sat || r_o[2].sat || r_o[3].sat;
    assign o_last_cell  = r_o_last;

    // ---------------- assertions ----------------
    // a count write restarts the scan
    a_cnt_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_wr |=> (r_pos_x == '0) && (r_pos_y == '0) && (r_pos_z == '0))
        else $error("scan not restarted after count write");

    // the scan never runs past the clamped counts
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos_x <= w_lim_x) && (r_pos_y <= w_lim_y) && (r_pos_z <= w_lim_z))
        else $error("scan position beyond grid");

    // the last cell wraps the scan to the origin
    a_grid_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_last |=> (r_pos_x == '0) && (r_pos_y == '0) && (r_pos_z == '0))
        else $error("scan did not wrap after last cell");

    // input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_v1 && r_v2 && r_v3 && r_vo && !i_out_ready)
        else $error("input stalled with a free stage");

endmodule

### test/tb_top.sv
// Self-checking bench for grid_backward_diff_grad_div: a clocked driver and
// monitor, plus an in-bench stencil predictor that tracks the scan position.
// Depends on gbd_pkg (t_cell, t_cfg_idx, widths, reset values) and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
    import gbd_pkg::*;

    localparam int MAX_AXIS    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ERR_SHOWN   = 10;

    // one result word as the block should present it
    typedef struct {
        logic signed [RES_W-1:0] gx;
        logic signed [RES_W-1:0] gy;
        logic signed [RES_W-1:0] gz;
        logic signed [RES_W-1:0] dv;
        logic                    sat;
        logic                    last;
    } t_stencil_word;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_cfg_wr_en  = 1'b0;
    logic [1:0]               i_cfg_index  = '0;
    logic [CFG_W-1:0]         i_cfg_data   = '0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_density    = '0;
    logic signed [DATA_W-1:0] i_vel_x      = '0;
    logic signed [DATA_W-1:0] i_vel_y      = '0;
    logic signed [DATA_W-1:0] i_vel_z      = '0;
    logic                     o_out_valid;
    logic                     i_out_ready  = 1'b0;
    logic signed [RES_W-1:0]  o_grad_x;
    logic signed [RES_W-1:0]  o_grad_y;
    logic signed [RES_W-1:0]  o_grad_z;
    logic signed [RES_W-1:0]  o_divergence;
    logic                     o_saturated;
    logic                     o_last_cell;

    grid_backward_diff_grad_div u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_density    (i_density),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_vel_z      (i_vel_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_grad_x     (o_grad_x),
        .o_grad_y     (o_grad_y),
        .o_grad_z     (o_grad_z),
        .o_divergence (o_divergence),
        .o_saturated  (o_saturated),
        .o_last_cell  (o_last_cell)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers, the plane store,
    // the z-neighbour register and the scan position.
    // ------------------------------------------------------------------
    logic [15:0] inv_len = INV_RESET;
    logic [4:0]  cnt_x   = COUNT_RESET;
    logic [4:0]  cnt_y   = COUNT_RESET;
    logic [4:0]  cnt_z   = COUNT_RESET;
    t_cell       plane_mem [MAX_AXIS*MAX_AXIS];
    t_cell       z_prev  = '0;
    int          pos_x   = 0;
    int          pos_y   = 0;
    int          pos_z   = 0;

    t_cell         cell_send_q[$];      // cells waiting for the driver
    t_stencil_word stencil_expect_q[$]; // results owed by the block
    t_cell         cur_word;            // cell currently on the input bus

    int  words_in    = 0;
    int  err_count   = 0;
    int  cycle_cnt   = 0;
    int  src_wait    = 0;
    int  sink_wait   = 0;
    bit  src_steady  = 1'b0;
    bit  sink_steady = 1'b0;
    bit  sink_hold   = 1'b0;

    // A count of zero behaves as one; anything past the store size clamps.
    function automatic int axis_len(input logic [4:0] c);
        if (c == 5'd0)
            return 1;
        return (int'(c) > MAX_AXIS) ? MAX_AXIS : int'(c);
    endfunction

    function automatic longint sx16(input logic [DATA_W-1:0] v);
        return longint'($signed(v));
    endfunction

    // Multiply a Q4.12 difference by the reciprocal, round half up, clip.
    function automatic logic signed [RES_W-1:0] scale_clip(input longint d,
                                                           inout logic sat);
        longint r;
        r = (d * longint'(inv_len) + 2048) >>> FRAC_W;
        if (r > 64'sd8388607) begin
            r   = 64'sd8388607;
            sat = 1'b1;
        end else if (r < -64'sd8388608) begin
            r   = -64'sd8388608;
            sat = 1'b1;
        end
        return r[RES_W-1:0];
    endfunction

    // Work out the result of one cell, then store it and advance the scan.
    function automatic t_stencil_word stencil_predict(input t_cell cur);
        int            cx, cy, cz;
        t_cell         nx, ny, nz;
        longint        rho, dv;
        logic          sat;
        t_stencil_word w;
        cx  = axis_len(cnt_x);
        cy  = axis_len(cnt_y);
        cz  = axis_len(cnt_z);
        nx  = (pos_x > 0) ? plane_mem[pos_y*MAX_AXIS + pos_z] : '0;
        ny  = (pos_y > 0) ? plane_mem[(pos_y-1)*MAX_AXIS + pos_z] : '0;
        nz  = (pos_z > 0) ? z_prev : '0;
        sat = 1'b0;
        rho = sx16(cur.density);
        w.gx = scale_clip(rho - sx16(nx.density), sat);
        w.gy = scale_clip(rho - sx16(ny.density), sat);
        w.gz = scale_clip(rho - sx16(nz.density), sat);
        dv   = (sx16(cur.vel_x) - sx16(nx.vel_x)) + (sx16(cur.vel_y) - sx16(ny.vel_y))
             + (sx16(cur.vel_z) - sx16(nz.vel_z));
        w.dv   = scale_clip(dv, sat);
        w.sat  = sat;
        w.last = (pos_x == cx-1) && (pos_y == cy-1) && (pos_z == cz-1);

        plane_mem[pos_y*MAX_AXIS + pos_z] = cur;
        z_prev = cur;
        if (pos_z + 1 < cz) begin
            pos_z++;
        end else begin
            pos_z = 0;
            if (pos_y + 1 < cy) begin
                pos_y++;
            end else begin
                pos_y = 0;
                pos_x = (pos_x + 1 < cx) ? pos_x + 1 : 0;
            end
        end
        return w;
    endfunction

    // Idle cycles before the next word: mostly short, sometimes long,
    // none at all while a side is in a steady stretch.
    function automatic int draw_gap(input bit steady);
        if (steady)
            return 0;
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 2);
    endfunction

    function automatic logic [DATA_W-1:0] pick_field();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 63)) - 16'd32;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next cell once the drawn gap has run out; keep
    // valid high with the same payload until the word is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_cells
        int    gap;
        t_cell nxt;
        if (i_rst_n) begin
            gap = src_wait;
            if (i_in_valid && o_in_ready) begin
                stencil_expect_q.push_back(stencil_predict(cur_word));
                words_in++;
                gap = draw_gap(src_steady);
            end
            // hold the bus while a word is offered and not yet taken
            if (!(i_in_valid && !o_in_ready)) begin
                if (gap == 0 && cell_send_q.size() > 0) begin
                    nxt        = cell_send_q.pop_front();
                    cur_word   = nxt;
                    i_density  <= nxt.density;
                    i_vel_x    <= nxt.vel_x;
                    i_vel_y    <= nxt.vel_y;
                    i_vel_z    <= nxt.vel_z;
                    i_in_valid <= 1'b1;
                    src_wait   <= 0;
                end else begin
                    i_in_valid <= 1'b0;
                    src_wait   <= (gap > 0) ? gap - 1 : 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result with the oldest expectation, then
    // draw a stall before the next one. The long hold-off overrides ready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_stencil_word w;
        int            stall;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (stencil_expect_q.size() == 0) begin
                    err_count++;
                    if (err_count <= ERR_SHOWN)
                        $display("ERROR: result word with nothing expected: gx=%0d gy=%0d",
                                 o_grad_x, o_grad_y);
                end else begin
                    w = stencil_expect_q.pop_front();
                    if (o_grad_x !== w.gx || o_grad_y !== w.gy || o_grad_z !== w.gz ||
                        o_divergence !== w.dv || o_saturated !== w.sat ||
                        o_last_cell !== w.last) begin
                        err_count++;
                        if (err_count <= ERR_SHOWN) begin
                            $display("ERROR: exp gx=%0d gy=%0d gz=%0d div=%0d sat=%b last=%b",
                                     w.gx, w.gy, w.gz, w.dv, w.sat, w.last);
                            $display("       got gx=%0d gy=%0d gz=%0d div=%0d sat=%b last=%b",
                                     o_grad_x, o_grad_y, o_grad_z, o_divergence,
                                     o_saturated, o_last_cell);
                        end
                    end
                end
            end

            if (sink_hold) begin
                i_out_ready <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                stall = draw_gap(sink_steady);
                sink_wait   <= stall;
                i_out_ready <= (stall == 0);
            end else if (!i_out_ready) begin
                if (sink_wait == 0)
                    i_out_ready <= 1'b1;
                else
                    sink_wait <= sink_wait - 1;
            end
        end
    end

    // Long receiver hold-off in the middle of the random traffic: the sender
    // keeps offering, so the pipeline fills and input ready must drop.
    initial begin : sink_hold_off
        wait (words_in >= 480 && cell_send_q.size() >= 8);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Register write; mirror it into the predictor once the block has it.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INV_LEN: inv_len = val;
            CFG_X_COUNT: cnt_x   = val[4:0];
            CFG_Y_COUNT: cnt_y   = val[4:0];
            CFG_Z_COUNT: cnt_z   = val[4:0];
            default: ;
        endcase
        // any count write restarts the scan at the origin
        if (idx != CFG_INV_LEN) begin
            pos_x = 0;
            pos_y = 0;
            pos_z = 0;
        end
    endtask

    task automatic write_counts(input logic [4:0] nx, input logic [4:0] ny,
                                input logic [4:0] nz);
        write_reg(CFG_X_COUNT, {11'($urandom), nx});
        write_reg(CFG_Y_COUNT, {11'($urandom), ny});
        write_reg(CFG_Z_COUNT, {11'($urandom), nz});
    endtask

    task automatic push_cell(input logic [15:0] d, input logic [15:0] vx,
                             input logic [15:0] vy, input logic [15:0] vz);
        t_cell c;
        c.density = d;
        c.vel_x   = vx;
        c.vel_y   = vy;
        c.vel_z   = vz;
        cell_send_q.push_back(c);
    endtask

    task automatic push_random(input int n);
        repeat (n) push_cell(pick_field(), pick_field(), pick_field(), pick_field());
    endtask

    // Wait until every cell is taken and every result is back, then let the
    // pipeline settle before touching the registers.
    task automatic drain_idle();
        @(negedge i_clk);
        while (cell_send_q.size() != 0 || i_in_valid || stencil_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [4:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return 5'd0;
            1:       return 5'd16;
            2:       return 5'($urandom_range(17, 31));
            default: return 5'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [15:0] pick_inv();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'd2048;
            4:       return 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int total;
        int phase_no;
        int k;
        total    = 0;
        phase_no = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset registers: 3x3x3 grid, reciprocal 0.5; field extremes.
        push_cell(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_cell(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_cell(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_cell(16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF);
        drain_idle();

        // Reciprocal change alone keeps the scan where it was.
        write_reg(CFG_INV_LEN, 16'hFFFF);
        @(negedge i_clk);
        push_cell(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        push_cell(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        push_cell(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        push_cell(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        push_cell(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        drain_idle();

        // Small full grid with wrap: every neighbour used, last cell flagged.
        write_counts(5'd2, 5'd2, 5'd2);
        @(negedge i_clk);
        for (k = 0; k < 8; k++) begin
            case (k % 3)
                0:       push_cell(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                1:       push_cell(16'h8000, 16'h8000, 16'h8000, 16'h8000);
                default: push_cell(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
            endcase
        end
        drain_idle();

        // Zero counts act as one: every cell is a whole grid. Unit reciprocal
        // puts rounding ties at +/- half an LSB.
        write_reg(CFG_INV_LEN, 16'd1);
        write_counts(5'd0, 5'd0, 5'd0);
        @(negedge i_clk);
        push_cell(16'h0800, 16'h0800, 16'h0000, 16'h0000);
        push_cell(16'hF800, 16'hF800, 16'h0000, 16'h0000);
        push_cell(16'h0801, 16'h0400, 16'h0400, 16'hF7FF);
        drain_idle();
        total = 20;

        // Random phases: new settings between phases, random content within.
        while (total < 900) begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            if (phase_no == 2) begin
                // full plane: every store entry written, then read back at x > 0
                write_reg(CFG_INV_LEN, pick_inv());
                write_counts(5'd3, 5'd20, 5'd16);
                k = 280;
            end else begin
                case ($urandom_range(0, 9))
                    0: ;
                    1: write_reg(CFG_INV_LEN, pick_inv());
                    default: begin
                        write_reg(CFG_INV_LEN, pick_inv());
                        write_counts(pick_count(), pick_count(), pick_count());
                    end
                endcase
                k = $urandom_range(20, 120);
            end
            @(negedge i_clk);
            push_random(k);
            total += k;
            phase_no++;
            drain_idle();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
src/gbd_pkg.sv
src/gbd_cell.sv
src/gbd_row_chain.sv
src/gbd_plane_store.sv
src/grid_backward_diff_grad_div.sv
test/tb_top.sv
